@@ sv/mhsd_pkg.sv @@
// shared types and constants of the magic header stream deframer
package mhsd_pkg;

  localparam int unsigned HeaderBytes = 12;
  // bytes kept before the check; the final header byte comes straight from the input
  localparam int unsigned HdrStore    = HeaderBytes - 1;
  localparam int unsigned CntW        = $clog2(HeaderBytes);
  localparam int unsigned MagicPos    = 0;
  localparam int unsigned VersionPos  = 4;
  localparam int unsigned TypePos     = 5;
  localparam int unsigned RsvdPos     = 6;
  localparam int unsigned LenPos      = 8;

  localparam int unsigned MaxFrameW   = 25;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [31:0]          MagicRst   = 32'h0000_0000;
  localparam logic [7:0]           VersionRst = 8'd1;
  localparam logic [MaxFrameW-1:0] LimitRst   = MaxFrameW'(1048576 - HeaderBytes);

  typedef enum logic [CfgIdxW-1:0] {
    CfgMagic    = 2'd0,
    CfgVersion  = 2'd1,
    CfgMaxFrame = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEmpty   = 2'd1,
    KindError   = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    ErrMagic    = 2'd0,
    ErrVersion  = 2'd1,
    ErrReserved = 2'd2,
    ErrLength   = 2'd3
  } err_code_e;

  typedef logic [HdrStore-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic        bad;
    err_code_e   code;
    logic [31:0] len;
    logic [7:0]  ftype;
  } hdr_chk_t;

endpackage

@@ sv/mhsd_hdr_check.sv @@
// header validation: magic, version, reserved bytes and payload length limit
module mhsd_hdr_check (
  input  mhsd_pkg::hdr_bytes_t              hdr_i,
  input  logic [7:0]                        last_byte_i,
  input  logic [31:0]                       magic_i,
  input  logic [7:0]                        version_i,
  input  logic [mhsd_pkg::MaxFrameW-1:0]    limit_i,
  output mhsd_pkg::hdr_chk_t                chk_o
);

  logic [31:0] magic_rx;
  logic [31:0] len;
  logic        magic_bad, version_bad, rsvd_bad, len_bad;

  assign magic_rx = {hdr_i[mhsd_pkg::MagicPos+3], hdr_i[mhsd_pkg::MagicPos+2],
                     hdr_i[mhsd_pkg::MagicPos+1], hdr_i[mhsd_pkg::MagicPos]};
  assign len      = {last_byte_i, hdr_i[mhsd_pkg::LenPos+2],
                     hdr_i[mhsd_pkg::LenPos+1], hdr_i[mhsd_pkg::LenPos]};

  assign magic_bad   = (magic_rx != magic_i);
  assign version_bad = (hdr_i[mhsd_pkg::VersionPos] != version_i);
  assign rsvd_bad    = (hdr_i[mhsd_pkg::RsvdPos] != 8'd0) ||
                       (hdr_i[mhsd_pkg::RsvdPos+1] != 8'd0);
  assign len_bad     = (len > {{(32-mhsd_pkg::MaxFrameW){1'b0}}, limit_i});

  always_comb begin
    chk_o.bad   = magic_bad | version_bad | rsvd_bad | len_bad;
    chk_o.len   = len;
    chk_o.ftype = hdr_i[mhsd_pkg::TypePos];
    // first failing check wins
    if (magic_bad) begin
      chk_o.code = mhsd_pkg::ErrMagic;
    end else if (version_bad) begin
      chk_o.code = mhsd_pkg::ErrVersion;
    end else if (rsvd_bad) begin
      chk_o.code = mhsd_pkg::ErrReserved;
    end else begin
      chk_o.code = mhsd_pkg::ErrLength;
    end
  end

endmodule

@@ sv/magic_header_stream_deframer.sv @@
// Byte-stream deframer: one byte per transaction in, at most one result per byte out.
// Each input byte is accepted and its result lands in an output register,
// so the block sustains one byte per clock; the input stalls only while the output
// register is full and not being taken. Frames carry a 12-byte little-endian header
// (magic, version, type, two zero bytes, 32-bit payload length) checked on its last
// byte; payload bytes stream out tagged with the frame type, tlast on the final one,
// and a zero-length frame yields one empty-frame marker. A failed check emits one
// error result and then every later byte is dropped until reset. The length limit
// is max_frame_bytes minus the header size, saturating at zero, worked out when the
// register is written.
module magic_header_stream_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [mhsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mhsd_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] in_byte
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,   // [7:0] frame_type, [15:8] data_byte,
                                                   // [17:16] error_code, [23:18] zero
  output logic [1:0]                    m_tuser,   // [1:0] out_kind
  output logic                          m_tlast    // last_of_frame
);

  localparam logic [mhsd_pkg::CntW-1:0] LastCnt = mhsd_pkg::CntW'(mhsd_pkg::HeaderBytes - 1);

  // configuration
  logic [31:0]                    magic_q;
  logic [7:0]                     version_q;
  logic [mhsd_pkg::MaxFrameW-1:0] limit_q, limit_d, cfg_max;

  // parse state
  mhsd_pkg::hdr_bytes_t           hdr_q;
  logic [mhsd_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [31:0]                    rem_q, rem_d;
  logic [7:0]                     type_q, type_d;
  logic                           err_q, err_d;

  // result register
  logic                           out_valid_q, out_valid_d;
  mhsd_pkg::out_kind_e            kind_q, kind_d;
  logic [7:0]                     ftype_q, ftype_d;
  logic [7:0]                     data_q, data_d;
  logic                           last_q, last_d;
  mhsd_pkg::err_code_e            code_q, code_d;

  logic                           accept, out_load, hdr_wr;
  mhsd_pkg::hdr_chk_t             chk;

  assign cfg_max = cfg_data_i[mhsd_pkg::MaxFrameW-1:0];
  assign limit_d = (cfg_max >= mhsd_pkg::MaxFrameW'(mhsd_pkg::HeaderBytes)) ?
                   cfg_max - mhsd_pkg::MaxFrameW'(mhsd_pkg::HeaderBytes) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= mhsd_pkg::MagicRst;
      version_q <= mhsd_pkg::VersionRst;
      limit_q   <= mhsd_pkg::LimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mhsd_pkg::CfgMagic:    magic_q   <= cfg_data_i;
        mhsd_pkg::CfgVersion:  version_q <= cfg_data_i[7:0];
        mhsd_pkg::CfgMaxFrame: limit_q   <= limit_d;
        default: ;
      endcase
    end
  end

  mhsd_hdr_check u_check (
    .hdr_i       (hdr_q),
    .last_byte_i (s_tdata),
    .magic_i     (magic_q),
    .version_i   (version_q),
    .limit_i     (limit_q),
    .chk_o       (chk)
  );

  assign s_tready = !out_valid_q || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    type_d   = type_q;
    err_d    = err_q;
    out_load = 1'b0;
    hdr_wr   = 1'b0;
    kind_d   = mhsd_pkg::KindPayload;
    ftype_d  = type_q;
    data_d   = 8'd0;
    last_d   = 1'b0;
    code_d   = mhsd_pkg::ErrMagic;
    if (accept && !err_q) begin
      if (rem_q != 32'd0) begin
        rem_d    = rem_q - 32'd1;
        out_load = 1'b1;
        data_d   = s_tdata;
        last_d   = (rem_q == 32'd1);
      end else if (cnt_q != LastCnt) begin
        hdr_wr = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end else begin
        cnt_d = '0;
        if (chk.bad) begin
          err_d    = 1'b1;
          out_load = 1'b1;
          kind_d   = mhsd_pkg::KindError;
          ftype_d  = 8'd0;
          code_d   = chk.code;
        end else begin
          type_d = chk.ftype;
          rem_d  = chk.len;
          if (chk.len == 32'd0) begin
            out_load = 1'b1;
            kind_d   = mhsd_pkg::KindEmpty;
            ftype_d  = chk.ftype;
            last_d   = 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !m_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rem_q       <= '0;
      type_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      type_q      <= type_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // header bytes hold no reset; each is written before it is checked
  always_ff @(posedge clk_i) begin
    if (hdr_wr) begin
      hdr_q[cnt_q] <= s_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_d;
      ftype_q <= ftype_d;
      data_q  <= data_d;
      last_q  <= last_d;
      code_q  <= code_d;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {6'd0, code_q, data_q, ftype_q};
  assign m_tuser  = kind_q;
  assign m_tlast  = last_q;

  // the error latch only clears on reset
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |=> err_q)
    else $error("error latch cleared");

  // nothing is produced once an error is latched
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q |-> !out_load)
    else $error("result produced after error");

  // no header collection while payload is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni) (rem_q != 32'd0) |-> (cnt_q == '0))
    else $error("header count moved during payload");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !m_tready) |-> !out_load)
    else $error("result register overwritten");

  // an error result latches the error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_load && kind_d == mhsd_pkg::KindError) |=> err_q)
    else $error("error result without latch");

endmodule
